>>> sv/sgds_pkg.sv
// Shared types, widths and helpers for the scan gap direction select block.
// Used by sgds_edge_calc and scan_gap_direction_select_core; no dependencies.
package sgds_pkg;

  localparam int MaxBeams = 4096;
  localparam int IdxW     = $clog2(MaxBeams);
  localparam int RunW     = 13;
  localparam int RangeW   = 16;
  localparam int MvbW     = 13;
  localparam int StepW    = 18;
  localparam int HeadW    = 31;
  localparam int DistW    = 32;
  localparam int EdgeW    = 34;
  localparam int LowW     = 33;
  localparam int HighW    = IdxW + StepW;
  localparam int HalfW    = MvbW + StepW - 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [RunW-1:0] RunMax = '1;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxBeams - 1);

  localparam logic signed [EdgeW-1:0] HeadMax = 34'sd1073741823;
  localparam logic signed [EdgeW-1:0] HeadMin = -34'sd1073741824;

  localparam logic [RangeW-1:0]   SafeRangeRst  = 16'd500;
  localparam logic [RangeW-1:0]   StuckRangeRst = 16'd250;
  localparam logic [MvbW-1:0]     MinValleyRst  = 13'd87;
  localparam logic [StepW-1:0]    AngleStepRst  = 18'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAFE_RANGE   = 3'd0,
    CFG_STUCK_RANGE  = 3'd1,
    CFG_MIN_VALLEY   = 3'd2,
    CFG_ANGLE_STEP   = 3'd3,
    CFG_USER_HEADING = 3'd4,
    CFG_STOP_REQ     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_USER   = 2'd0,
    KIND_ROTATE = 2'd1,
    KIND_EDGE   = 2'd2
  } kind_e;

  // one beam after the run counters, on its way to the edge math
  typedef struct packed {
    logic            last;
    logic            stuck;
    logic            close;
    logic [IdxW-1:0] beam;
    logic [RunW-1:0] run;
  } beam_evt_t;

  // edges of a closed valley, ready for the running minimum
  typedef struct packed {
    logic                    last;
    logic                    stuck;
    logic                    close;
    logic                    in_area;
    logic signed [HeadW-1:0] right_edge;
    logic signed [HeadW-1:0] left_edge;
    logic [DistW-1:0]        right_dist;
    logic [DistW-1:0]        left_dist;
  } edge_evt_t;

  function automatic logic signed [HeadW-1:0] sat_head(logic signed [EdgeW-1:0] v);
    logic signed [EdgeW-1:0] c;
    if (v > HeadMax) begin
      c = HeadMax;
    end else if (v < HeadMin) begin
      c = HeadMin;
    end else begin
      c = v;
    end
    return c[HeadW-1:0];
  endfunction

  function automatic logic [DistW-1:0] abs_dist(logic signed [HeadW-1:0] a,
                                               logic signed [HeadW-1:0] b);
    logic signed [DistW-1:0] d;
    d = $signed({a[HeadW-1], a}) - $signed({b[HeadW-1], b});
    if (d < 0) begin
      d = -d;
    end
    return d;
  endfunction

endpackage

>>> sv/sgds_edge_calc.sv
// Valley edge pipeline: multiply, add, saturate and measure against the heading.
// Three register stages; depends on sgds_pkg.
module sgds_edge_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  sgds_pkg::beam_evt_t               evt_i,
  input  logic [sgds_pkg::StepW-1:0]        angle_step_i,
  input  logic [sgds_pkg::MvbW-1:0]         min_valley_i,
  input  logic signed [sgds_pkg::HeadW-1:0] user_heading_i,
  output logic                              valid_o,
  output sgds_pkg::edge_evt_t               evt_o
);

  localparam int DiffW = sgds_pkg::IdxW + 2;

  // stage b: products
  logic                                 b_valid_q;
  logic                                 b_last_q, b_stuck_q, b_close_q;
  logic signed [sgds_pkg::LowW-1:0]     b_low_q, b_low_d;
  logic [sgds_pkg::HighW-1:0]           b_high_q, b_high_d;
  logic [sgds_pkg::HalfW-1:0]           b_half_q;
  logic [sgds_pkg::HalfW:0]             half_prod;
  logic signed [DiffW-1:0]              diff;

  // stage c: exact edges
  logic                                 c_valid_q;
  logic                                 c_last_q, c_stuck_q, c_close_q, c_inside_q;
  logic signed [sgds_pkg::EdgeW-1:0]    c_right_q, c_left_q, c_right_d, c_left_d;
  logic signed [sgds_pkg::EdgeW-1:0]    heading_ext;

  // stage d: saturated edges and distances
  logic                                 d_valid_q;
  sgds_pkg::edge_evt_t                  d_evt_q, d_evt_d;

  assign diff = $signed({2'b00, evt_i.beam}) - $signed({1'b0, evt_i.run});

  always_comb begin
    b_low_d   = $signed({{(sgds_pkg::LowW - DiffW){diff[DiffW-1]}}, diff})
              * $signed({{(sgds_pkg::LowW - sgds_pkg::StepW){1'b0}}, angle_step_i});
    b_high_d  = {{sgds_pkg::StepW{1'b0}}, evt_i.beam}
              * {{sgds_pkg::IdxW{1'b0}}, angle_step_i};
    half_prod = {{sgds_pkg::StepW{1'b0}}, min_valley_i}
              * {{sgds_pkg::MvbW{1'b0}}, angle_step_i};
  end

  assign heading_ext = {{(sgds_pkg::EdgeW - sgds_pkg::HeadW){user_heading_i[sgds_pkg::HeadW-1]}},
                        user_heading_i};

  always_comb begin
    c_right_d = {b_low_q[sgds_pkg::LowW-1], b_low_q}
              + $signed({{(sgds_pkg::EdgeW - sgds_pkg::HalfW){1'b0}}, b_half_q});
    c_left_d  = $signed({{(sgds_pkg::EdgeW - sgds_pkg::HighW){1'b0}}, b_high_q})
              - $signed({{(sgds_pkg::EdgeW - sgds_pkg::HalfW){1'b0}}, b_half_q});
  end

  always_comb begin
    d_evt_d.last       = c_last_q;
    d_evt_d.stuck      = c_stuck_q;
    d_evt_d.close      = c_close_q;
    d_evt_d.in_area    = c_inside_q;
    d_evt_d.right_edge = sgds_pkg::sat_head(c_right_q);
    d_evt_d.left_edge  = sgds_pkg::sat_head(c_left_q);
    d_evt_d.right_dist = sgds_pkg::abs_dist(d_evt_d.right_edge, user_heading_i);
    d_evt_d.left_dist  = sgds_pkg::abs_dist(d_evt_d.left_edge, user_heading_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= valid_i;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_last_q   <= evt_i.last;
      b_stuck_q  <= evt_i.stuck;
      b_close_q  <= evt_i.close;
      b_low_q    <= b_low_d;
      b_high_q   <= b_high_d;
      b_half_q   <= half_prod[sgds_pkg::HalfW:1];
      c_last_q   <= b_last_q;
      c_stuck_q  <= b_stuck_q;
      c_close_q  <= b_close_q;
      c_right_q  <= c_right_d;
      c_left_q   <= c_left_d;
      // inclusive test on the exact edges, before saturation
      c_inside_q <= (heading_ext >= c_right_d) && (heading_ext <= c_left_d);
      d_evt_q    <= d_evt_d;
    end
  end

  assign valid_o = d_valid_q;
  assign evt_o   = d_evt_q;

endmodule

>>> sv/scan_gap_direction_select_core.sv
// Top level of the scan gap direction select block: run counters, result choice.
// Depends on sgds_pkg and sgds_edge_calc.
//
// Usage: one laser beam per transfer on the s_axis channel (range in tdata,
// not-a-number flag in tuser, tlast on the final beam of a scan). Runs of safe
// beams form valleys; their shrunk bounds are checked against the user
// heading. One result leaves on m_axis per scan, after the tlast beam.
// Throughput: one beam per cycle while s_axis_tready is high, including across
// scan ends. The result of a scan reaches m_axis from its accepted tlast beam
// through the input register, the edge stages b, c and d and the output register.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i; change
// it only while no beam is in flight.
// Reset: all scan state clears, registers return to their defaults, no
// result is pending.
// Stall: a held result does not block beams; s_axis_tready drops only when a
// second scan end reaches the output while the previous result is still
// waiting on m_axis_tready.
module scan_gap_direction_select_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // beam stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [15:0] range_mm
  input  logic [0:0]                          s_axis_tuser,  // [0] range_invalid
  input  logic                                s_axis_tlast,  // last_beam
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,  // [30:0] heading_out
  output logic [2:0]                          m_axis_tuser,  // [0] stop_flag, [2:1] choice_kind
  // configuration
  input  logic                                cfg_we_i,
  input  logic [sgds_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sgds_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  // configuration registers
  logic [sgds_pkg::RangeW-1:0]       safe_range_q, stuck_range_q;
  logic [sgds_pkg::MvbW-1:0]         min_valley_q;
  logic [sgds_pkg::StepW-1:0]        angle_step_q;
  logic signed [sgds_pkg::HeadW-1:0] user_heading_q;
  logic                              stop_req_q;

  // run counters
  logic [sgds_pkg::IdxW-1:0] beam_idx_q, beam_idx_d;
  logic [sgds_pkg::RunW-1:0] run_q, run_d, run_inc, run_cnt;
  logic                      beam_safe, beam_stuck, accept, adv;

  logic                      a_valid_q;
  sgds_pkg::beam_evt_t       a_evt_q, a_evt_d;

  logic                      d_valid;
  sgds_pkg::edge_evt_t       d_evt;

  // scan accumulators
  logic                              stuck_q, valley_q, inside_q;
  logic                              stuck_n, valley_n, inside_n;
  logic signed [sgds_pkg::HeadW-1:0] best_edge_q, best_edge_n, edge1;
  logic [sgds_pkg::DistW-1:0]        best_dist_q, best_dist_n, dist1;
  logic                              out_load;

  // result register
  logic                              out_valid_q;
  logic                              out_stop_q;
  sgds_pkg::kind_e                   out_kind_q, kind_d;
  logic signed [sgds_pkg::HeadW-1:0] out_head_q, head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_range_q   <= sgds_pkg::SafeRangeRst;
      stuck_range_q  <= sgds_pkg::StuckRangeRst;
      min_valley_q   <= sgds_pkg::MinValleyRst;
      angle_step_q   <= sgds_pkg::AngleStepRst;
      user_heading_q <= '0;
      stop_req_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgds_pkg::CFG_SAFE_RANGE:   safe_range_q   <= cfg_wdata_i[sgds_pkg::RangeW-1:0];
        sgds_pkg::CFG_STUCK_RANGE:  stuck_range_q  <= cfg_wdata_i[sgds_pkg::RangeW-1:0];
        sgds_pkg::CFG_MIN_VALLEY:   min_valley_q   <= cfg_wdata_i[sgds_pkg::MvbW-1:0];
        sgds_pkg::CFG_ANGLE_STEP:   angle_step_q   <= cfg_wdata_i[sgds_pkg::StepW-1:0];
        sgds_pkg::CFG_USER_HEADING: user_heading_q <= $signed(cfg_wdata_i[sgds_pkg::HeadW-1:0]);
        sgds_pkg::CFG_STOP_REQ:     stop_req_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // only a scan end that finds the output still occupied holds the pipeline
  assign adv    = !(d_valid && d_evt.last && out_valid_q && !m_axis_tready);
  assign accept = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  always_comb begin
    beam_safe  = s_axis_tuser[0] || (s_axis_tdata >= safe_range_q);
    beam_stuck = !s_axis_tuser[0] && (s_axis_tdata <= stuck_range_q);
    run_inc    = (run_q == sgds_pkg::RunMax) ? run_q : run_q + 1'b1;
    run_cnt    = beam_safe ? run_inc : run_q;
    run_d      = run_inc;
    a_evt_d.close = 1'b0;
    if (!beam_safe || s_axis_tlast) begin
      run_d = '0;
      // a zero minimum still needs one beam
      a_evt_d.close = (run_cnt != '0) && (run_cnt >= min_valley_q);
    end
    a_evt_d.last  = s_axis_tlast;
    a_evt_d.stuck = beam_stuck;
    a_evt_d.beam  = beam_idx_q;
    a_evt_d.run   = run_cnt;
    if (s_axis_tlast) begin
      beam_idx_d = '0;
    end else if (beam_idx_q == sgds_pkg::IdxMax) begin
      beam_idx_d = beam_idx_q;
    end else begin
      beam_idx_d = beam_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_idx_q <= '0;
      run_q      <= '0;
      a_valid_q  <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
      if (s_axis_tvalid) begin
        beam_idx_q <= beam_idx_d;
        run_q      <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_evt_q <= a_evt_d;
    end
  end

  sgds_edge_calc u_edge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (a_valid_q),
    .evt_i          (a_evt_q),
    .angle_step_i   (angle_step_q),
    .min_valley_i   (min_valley_q),
    .user_heading_i (user_heading_q),
    .valid_o        (d_valid),
    .evt_o          (d_evt)
  );

  // right edge first, then left; strict compare keeps the earlier one on ties
  always_comb begin
    dist1 = best_dist_q;
    edge1 = best_edge_q;
    if (d_evt.close && (d_evt.right_dist < best_dist_q)) begin
      dist1 = d_evt.right_dist;
      edge1 = d_evt.right_edge;
    end
    best_dist_n = dist1;
    best_edge_n = edge1;
    if (d_evt.close && (d_evt.left_dist < dist1)) begin
      best_dist_n = d_evt.left_dist;
      best_edge_n = d_evt.left_edge;
    end
    valley_n = valley_q || d_evt.close;
    inside_n = inside_q || (d_evt.close && d_evt.in_area);
    stuck_n  = stuck_q || d_evt.stuck;
    if (inside_n) begin
      kind_d = sgds_pkg::KIND_USER;
      head_d = user_heading_q;
    end else if (!valley_n || stuck_n) begin
      kind_d = sgds_pkg::KIND_ROTATE;
      head_d = '0;
    end else begin
      kind_d = sgds_pkg::KIND_EDGE;
      head_d = best_edge_n;
    end
  end

  assign out_load = adv && d_valid && d_evt.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_q     <= 1'b0;
      valley_q    <= 1'b0;
      inside_q    <= 1'b0;
      best_edge_q <= '0;
      best_dist_q <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (adv && d_valid) begin
        if (d_evt.last) begin
          stuck_q     <= 1'b0;
          valley_q    <= 1'b0;
          inside_q    <= 1'b0;
          best_edge_q <= '0;
          best_dist_q <= '1;
        end else begin
          stuck_q     <= stuck_n;
          valley_q    <= valley_n;
          inside_q    <= inside_n;
          best_edge_q <= best_edge_n;
          best_dist_q <= best_dist_n;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stop_q <= stop_req_q;
      out_kind_q <= kind_d;
      out_head_q <= head_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_head_q};
  assign m_axis_tuser  = {out_kind_q, out_stop_q};

  // scan accumulators start over once a result is taken in
  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (best_dist_q == '1) && !valley_q && !inside_q && !stuck_q)
    else $error("scan accumulators not cleared after scan end");

  a_counters_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (beam_idx_q == '0) && (run_q == '0))
    else $error("run counters not cleared after last beam");

  a_rotate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:1] == sgds_pkg::KIND_ROTATE)) |->
      (m_axis_tdata == '0))
    else $error("rotate result carries a nonzero heading");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && d_valid && d_evt.last))
    else $error("input stalled without a blocked result");

  a_result_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule
